// ===== rtl/core/ired_pkg.sv =====
// Package for the IR edge interval frame decoder.
// Holds configuration codes, reset values, slot quantizer constants and shared types.
// No dependencies.
`default_nettype none

package ired_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_US_TICK_COUNT = 80;
	localparam int DEF_TIMER_BITS    = 24;
	localparam int DEF_FRAME_BITS    = 64;

	// Configuration port layout and register indexes.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_LIMIT_US    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_FRAME_SLOTS = 2'd1;

	// Register reset values.
	localparam logic [15:0] GAP_LIMIT_RESET = 16'd10000;
	localparam logic [7:0]  MIN_SLOTS_RESET = 8'd50;

	// Slot quantizer: slots = (us + 68) / 136, computed as ((us + 68) >> 3) / 17.
	// The divide by 17 uses an exact reciprocal for a 10-bit dividend.
	localparam int SLOT_ARG_BITS    = 12;
	localparam int SLOT_SUM_BITS    = 13;
	localparam int SLOT_PRE_SHIFT   = 3;
	localparam int SLOT_QIN_BITS    = 10;
	localparam int SLOT_MULT_BITS   = 11;
	localparam int SLOT_DIV_SHIFT   = 15;
	localparam int SLOT_BITS        = 6;
	localparam int SLOT_ROUND       = 68;
	localparam int SLOT_LIMIT       = 20;
	localparam logic [SLOT_MULT_BITS-1:0] SLOT_DIV_MULT = 11'd1928;

	// Slot total saturation.
	localparam int TOTAL_BITS = 8;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 8'd255;

	// Result queue depth; it also bounds the items in flight.
	localparam int OUT_FIFO_DEPTH = 4;

	// Configuration registers as seen by the frame logic.
	typedef struct packed {
		logic [15:0] gap_limit_us;
		logic [7:0]  min_frame_slots;
	} ired_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/ired_interval.sv =====
// Interval measurement: edge timestamp difference and conversion to microseconds.
// Two register stages: tick difference, then exact reciprocal multiply.
// Depends on ired_pkg.
`default_nettype none

module ired_interval #(
	parameter int US_TICK_COUNT = ired_pkg::DEF_US_TICK_COUNT,
	parameter int TIMER_BITS    = ired_pkg::DEF_TIMER_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [TIMER_BITS-1:0] edge_time,
	output logic                       us_valid,
	output logic [TIMER_BITS-1:0]      us_value,
	output logic [1:0]                 pipe_valid
);
	import ired_pkg::*;

	// Reciprocal for an exact floor divide of any TIMER_BITS-bit tick count.
	localparam int RECIP_L = $clog2(US_TICK_COUNT);
	localparam int SHIFT   = TIMER_BITS + RECIP_L;
	localparam int M_BITS  = TIMER_BITS + 1;
	localparam int P_BITS  = TIMER_BITS + M_BITS;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + 64'(US_TICK_COUNT) - 64'd1) / 64'(US_TICK_COUNT);
	localparam logic [M_BITS-1:0] RECIP = M_BITS'(RECIP_FULL);

	logic [TIMER_BITS-1:0] prev_q;
	logic [TIMER_BITS-1:0] ticks_s1;
	logic                  valid_s1;
	logic [TIMER_BITS-1:0] us_s2;
	logic                  valid_s2;
	logic [P_BITS-1:0]     product;

	// The tick difference wraps modulo the timer width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				prev_q <= edge_time;
			end
		end
	end

	// The quotient always fits the timer width, so the high part is narrowed to it.
	always_ff @(posedge clk) begin
		if (accept) begin
			ticks_s1 <= prev_q - edge_time;
		end
		us_s2 <= TIMER_BITS'(product[P_BITS-1:SHIFT]);
	end

	// Multiply by the rounded-up reciprocal; the high part is the quotient.
	assign product = P_BITS'(ticks_s1) * P_BITS'(RECIP);

	assign us_valid   = valid_s2;
	assign us_value   = us_s2;
	assign pipe_valid = {valid_s2, valid_s1};

endmodule

`default_nettype wire

// ===== rtl/core/ired_frame.sv =====
// Frame assembly: gap detection, slot quantization and the frame shift register.
// Pushes the completed frame to the result queue when a gap closes a long frame.
// Depends on ired_pkg.
`default_nettype none

module ired_frame #(
	parameter int TIMER_BITS = ired_pkg::DEF_TIMER_BITS,
	parameter int FRAME_BITS = ired_pkg::DEF_FRAME_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ired_pkg::ired_cfg_t    cfg,
	input  wire logic                   us_valid,
	input  wire logic [TIMER_BITS-1:0]  us_value,
	output logic                        push,
	output logic [FRAME_BITS-1:0]       push_data
);
	import ired_pkg::*;

	logic [FRAME_BITS-1:0]                 frame_q;
	logic [TOTAL_BITS-1:0]                 total_q;
	logic                                  gap_hit;
	logic                                  arg_small;
	logic [SLOT_SUM_BITS-1:0]              rounded;
	logic [SLOT_QIN_BITS-1:0]              eighths;
	logic [SLOT_QIN_BITS+SLOT_MULT_BITS-1:0] slot_prod;
	logic [SLOT_BITS-1:0]                  slots;
	logic                                  slot_ok;
	logic [FRAME_BITS-1:0]                 ones;
	logic [TOTAL_BITS:0]                   total_sum;
	logic [TOTAL_BITS-1:0]                 total_next;

	// An interval above the gap limit ends the frame.
	assign gap_hit = us_value > TIMER_BITS'(cfg.gap_limit_us);

	// Quantize to slots; anything at or above the argument range is 20 slots or more.
	assign arg_small = (us_value >> SLOT_ARG_BITS) == '0;
	assign rounded   = SLOT_SUM_BITS'(us_value[SLOT_ARG_BITS-1:0]) + SLOT_SUM_BITS'(SLOT_ROUND);
	assign eighths   = rounded[SLOT_PRE_SHIFT +: SLOT_QIN_BITS];
	assign slot_prod = (SLOT_QIN_BITS+SLOT_MULT_BITS)'(eighths)
		* (SLOT_QIN_BITS+SLOT_MULT_BITS)'(SLOT_DIV_MULT);
	assign slots     = slot_prod[SLOT_DIV_SHIFT +: SLOT_BITS];
	assign slot_ok   = arg_small && (slots != '0) && (slots < SLOT_BITS'(SLOT_LIMIT));

	// Ones that enter below the shifted frame: slots minus one of them.
	always_comb begin
		ones = '0;
		for (int i = 0; i < SLOT_LIMIT - 1; i++) begin
			ones[i] = slots > SLOT_BITS'(i + 1);
		end
	end

	// Saturating slot total.
	assign total_sum  = (TOTAL_BITS+1)'(total_q) + (TOTAL_BITS+1)'(slots);
	assign total_next = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			total_q <= '0;
		end else if (us_valid) begin
			if (gap_hit) begin
				frame_q <= '0;
				total_q <= '0;
			end else if (slot_ok) begin
				frame_q <= (frame_q << slots) | ones;
				total_q <= total_next;
			end
		end
	end

	// A gap emits the frame only if enough slots were collected.
	assign push      = us_valid && gap_hit && (total_q > cfg.min_frame_slots);
	assign push_data = frame_q;

endmodule

`default_nettype wire

// ===== rtl/core/ired_out_fifo.sv =====
// Small result queue between the frame logic and the output channel.
// The caller guarantees no push while full; depth is a parameter.
// No package dependencies.
`default_nettype none

module ired_out_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [WIDTH-1:0]                out_data,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign pop = out_valid && out_ready;

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;

endmodule

`default_nettype wire

// ===== rtl/core/ir_edge_interval_frame_decoder.sv =====
// Top level of the IR edge interval frame decoder.
// Instantiates ired_interval, ired_frame and ired_out_fifo; depends on ired_pkg.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_ready, edge_time         | in
//   result  | out_valid, out_ready, frame_code      | out
//   config  | cfg_valid, cfg_ready, cfg_index/data  | in
//
// One item is accepted per cycle while in_ready is high. The edge item that closes
// a frame passes the tick difference and reciprocal multiply registers, and its
// frame is then registered into the result queue, which raises out_valid.
// The result queue holds four items; in_ready drops when queued results plus
// items in the two measurement stages reach four, so a stalled output stops input.
// cfg_ready is always high. Reset clears the timestamp, frame, count and queue and
// loads the register reset values.
`default_nettype none

module ir_edge_interval_frame_decoder #(
	parameter int US_TICK_COUNT = ired_pkg::DEF_US_TICK_COUNT,
	parameter int TIMER_BITS    = ired_pkg::DEF_TIMER_BITS,
	parameter int FRAME_BITS    = ired_pkg::DEF_FRAME_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [TIMER_BITS-1:0]              edge_time,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [FRAME_BITS-1:0]                   frame_code,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ired_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [ired_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import ired_pkg::*;

	localparam int CNT_BITS = $clog2(OUT_FIFO_DEPTH + 1);

	ired_cfg_t             cfg_q;
	logic                  accept;
	logic                  us_valid;
	logic [TIMER_BITS-1:0] us_value;
	logic [1:0]            pipe_valid;
	logic                  push;
	logic [FRAME_BITS-1:0] push_data;
	logic [CNT_BITS-1:0]   fifo_count;
	logic [CNT_BITS:0]     in_flight;

	// Configuration registers; writes beyond the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit_us    <= GAP_LIMIT_RESET;
			cfg_q.min_frame_slots <= MIN_SLOTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAP_LIMIT_US:    cfg_q.gap_limit_us    <= cfg_data[15:0];
				CFG_MIN_FRAME_SLOTS: cfg_q.min_frame_slots <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Admit an item only if the queue has room for every item still in flight.
	assign in_flight = (CNT_BITS+1)'(fifo_count) + (CNT_BITS+1)'(pipe_valid[0])
		+ (CNT_BITS+1)'(pipe_valid[1]);
	assign in_ready  = in_flight < (CNT_BITS+1)'(OUT_FIFO_DEPTH);
	assign accept    = in_valid && in_ready;

	ired_interval #(
		.US_TICK_COUNT(US_TICK_COUNT),
		.TIMER_BITS   (TIMER_BITS)
	) u_interval (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.edge_time (edge_time),
		.us_valid  (us_valid),
		.us_value  (us_value),
		.pipe_valid(pipe_valid)
	);

	ired_frame #(
		.TIMER_BITS(TIMER_BITS),
		.FRAME_BITS(FRAME_BITS)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.us_valid (us_valid),
		.us_value (us_value),
		.push     (push),
		.push_data(push_data)
	);

	ired_out_fifo #(
		.WIDTH(FRAME_BITS),
		.DEPTH(OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (frame_code),
		.count    (fifo_count)
	);

endmodule

`default_nettype wire

// ===== rtl/core/ired_checker.sv =====
// Port-level assertions for the IR edge interval frame decoder, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module ired_checker #(
	parameter int FRAME_BITS = 64
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [FRAME_BITS-1:0] frame_code
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_code))
		else $error("result changed while stalled");

	// A result only appears after an accepted edge item has passed the pipeline.
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result without a matching edge item");

	// Input back-pressure only happens while results are waiting.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty result queue");

endmodule

bind ir_edge_interval_frame_decoder ired_checker #(.FRAME_BITS(FRAME_BITS)) u_ired_checker (.*);

`default_nettype wire

// ===== tb/ired_frame_checker.sv =====
// Checker for the IR edge interval frame decoder: watches the edge, result and config channels.
// Predicts each completed frame and compares it with the block's output; depends on ired_pkg.
`timescale 1ns / 100ps

module ired_frame_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_ready,
	input  wire logic [ired_pkg::DEF_TIMER_BITS-1:0] edge_time,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic [ired_pkg::DEF_FRAME_BITS-1:0] frame_code,
	input  wire logic                                cfg_valid,
	input  wire logic                                cfg_ready,
	input  wire logic [ired_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [ired_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                                end_of_run,
	output int                                       error_count,
	output int                                       frames_pending
);
	import ired_pkg::*;

	localparam int TIMER_W = DEF_TIMER_BITS;
	localparam int FRAME_W = DEF_FRAME_BITS;
	localparam int TICKS   = DEF_US_TICK_COUNT;
	localparam int SLOT_US = 136;

	// Configuration and decoder state as the block should hold them.
	logic [15:0]        gap_limit;
	logic [7:0]         min_slots;
	logic [TIMER_W-1:0] last_edge;
	logic [FRAME_W-1:0] frame_acc;
	logic [7:0]         slot_count;

	logic [FRAME_W-1:0] frames_due[$];
	logic [FRAME_W-1:0] due_frame;
	int                 mismatches = 0;
	bit                 end_checked = 1'b0;

	task automatic report_error(input string msg);
		$display("[%0t] frame check: %s", $time, msg);
		mismatches++;
	endtask

	// Measures the interval to the previous edge, then either closes the frame
	// or shifts in the slots that the interval stands for.
	task automatic decode_edge(input logic [TIMER_W-1:0] now);
		logic [TIMER_W-1:0] ticks;
		logic [FRAME_W-1:0] fill;
		int unsigned        us;
		int unsigned        slots;
		int unsigned        total;
		ticks = last_edge - now;
		us = ticks / TICKS;
		last_edge = now;
		if (us > gap_limit) begin
			if (slot_count > min_slots)
				frames_due.push_back(frame_acc);
			frame_acc = '0;
			slot_count = '0;
		end else begin
			slots = (us + SLOT_ROUND) / SLOT_US;
			if (slots > 0 && slots < SLOT_LIMIT) begin
				fill = FRAME_W'(1);
				fill = (fill << (slots - 1)) - 1;
				frame_acc = (frame_acc << slots) | fill;
				total = slot_count + slots;
				slot_count = (total > TOTAL_MAX) ? TOTAL_MAX : 8'(total);
			end
		end
	endtask

	// Register writes are handled first, then edge items, then results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit = GAP_LIMIT_RESET;
			min_slots = MIN_SLOTS_RESET;
			last_edge = '0;
			frame_acc = '0;
			slot_count = '0;
			frames_due.delete();
			error_count <= 0;
			frames_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAP_LIMIT_US:    gap_limit = cfg_data;
					CFG_MIN_FRAME_SLOTS: min_slots = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				decode_edge(edge_time);
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					report_error($sformatf("frame_code %h with no frame due", frame_code));
				end else begin
					due_frame = frames_due.pop_front();
					if (frame_code !== due_frame)
						report_error($sformatf("frame_code %h, predicted %h",
							frame_code, due_frame));
				end
			end
			if (end_of_run && !end_checked) begin
				end_checked = 1'b1;
				if (frames_due.size() != 0)
					report_error($sformatf("%0d predicted frames never came out",
						frames_due.size()));
			end
			error_count <= mismatches;
			frames_pending <= frames_due.size();
		end
	end

endmodule

// ===== tb/tb_ir_edge_interval_frame_decoder.sv =====
// Testbench top for the IR edge interval frame decoder: clock, reset, edge and config stimulus.
// Instantiates the block and ired_frame_checker, which predicts and compares; depends on ired_pkg.
`timescale 1ns / 100ps

module tb_ir_edge_interval_frame_decoder;
	import ired_pkg::*;

	localparam int          TIMER_W      = DEF_TIMER_BITS;
	localparam int          FRAME_W      = DEF_FRAME_BITS;
	localparam int          TICKS        = DEF_US_TICK_COUNT;
	localparam int unsigned MAX_TICKS    = (1 << TIMER_W) - 1;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          HOLD_CYCLES  = 200;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_ready;
	logic [TIMER_W-1:0]        edge_time  = '0;
	logic                      out_valid;
	logic                      out_ready  = 1'b0;
	logic [FRAME_W-1:0]        frame_code;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;
	logic                      end_of_run = 1'b0;

	int                 error_count;
	int                 frames_pending;
	logic [TIMER_W-1:0] tx_time     = '0;
	logic [15:0]        cur_gap     = GAP_LIMIT_RESET;
	int unsigned        items_sent  = 0;
	int unsigned        cycle_count = 0;
	bit                 idle_on     = 1'b1;
	bit                 stall_on    = 1'b1;
	bit                 hold_req    = 1'b0;
	bit                 hold_done   = 1'b0;

	ir_edge_interval_frame_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.edge_time  (edge_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_code (frame_code),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	ired_frame_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.edge_time      (edge_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_code     (frame_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.end_of_run     (end_of_run),
		.error_count    (error_count),
		.frames_pending (frames_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offers one edge item, sometimes after a short idle burst, and waits for it to be taken.
	task automatic send_edge(input logic [TIMER_W-1:0] stamp);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		edge_time <= stamp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tx_time = stamp;
		items_sent++;
	endtask

	// Sends the edge that lies the given interval after the last one; the timer counts down.
	task automatic send_us(input int unsigned us, input int unsigned frac);
		int unsigned        ticks;
		logic [TIMER_W-1:0] step_ticks;
		ticks = us * TICKS + frac;
		if (us > MAX_TICKS / TICKS || ticks > MAX_TICKS)
			ticks = MAX_TICKS;
		step_ticks = TIMER_W'(ticks);
		send_edge(tx_time - step_ticks);
	endtask

	// An interval past the gap limit; now and then the smallest one that still closes the frame.
	task automatic send_gap();
		if ($urandom_range(0, 7) == 0)
			send_us(cur_gap + 1, $urandom_range(0, TICKS - 1));
		else
			send_us(cur_gap + 1 + $urandom_range(0, 30000), $urandom_range(0, TICKS - 1));
	endtask

	// One frame: mostly valid slot intervals, with some noise and early gaps, then a gap.
	task automatic send_frame(input int unsigned len_lo, input int unsigned len_hi);
		int unsigned len;
		int unsigned pick;
		int unsigned slots;
		len = $urandom_range(len_hi, len_lo);
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				slots = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : $urandom_range(1, 4);
				send_us(slots * 136 - 68 + $urandom_range(0, 135), $urandom_range(0, TICKS - 1));
			end else if (pick < 87) begin
				send_us($urandom_range(0, 67), $urandom_range(0, TICKS - 1));
			end else if (pick < 92) begin
				send_us($urandom_range(2652, 12000), $urandom_range(0, TICKS - 1));
			end else if (pick < 96) begin
				send_edge(TIMER_W'($urandom));
			end else begin
				send_gap();
			end
		end
		send_gap();
	endtask

	// Stops offering items and waits until every predicted frame has come out
	// and the pipeline has had time to empty.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back; upper data bits of the slot minimum are junk.
	task automatic load_settings(input logic [15:0] gap, input logic [7:0] min_slots);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_GAP_LIMIT_US;
		cfg_data <= gap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_MIN_FRAME_SLOTS;
		cfg_data <= {8'($urandom), min_slots};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_gap = gap;
	endtask

	task automatic run_phase(input logic [15:0] gap, input logic [7:0] min_slots,
			input int unsigned count, input int unsigned len_lo, input int unsigned len_hi,
			input bit hold_output);
		int unsigned stop_at;
		wait_drained();
		load_settings(gap, min_slots);
		if (hold_output)
			hold_req <= 1'b1;
		stop_at = items_sent + count;
		while (items_sent < stop_at) send_frame(len_lo, len_hi);
	endtask

	// Result side: random stall bursts, and one long hold-off when asked for.
	initial begin : receiver
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ir_edge_interval_frame_decoder test failed");
		$finish;
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset settings. The first edge is measured from
		// a previous time of zero; the next one wraps the whole timer range.
		send_edge({TIMER_W{1'b1}});
		send_edge('0);
		// Slot rounding edges: zero slots, one slot, 19 slots, and 20 slots
		// inside the gap limit, which is ignored.
		send_us(67, TICKS - 1);
		send_us(68, 0);
		send_us(2651, TICKS - 1);
		send_us(2652, 0);
		// Exactly at the gap limit does not close the frame.
		send_us(10000, TICKS - 1);
		// Enough long slots to saturate the slot total and overflow the frame.
		repeat (14) send_us(19 * 136, $urandom_range(0, TICKS - 1));
		send_us(10001, 0);
		// A frame too short to be emitted is still cleared at the gap.
		send_us(272, 0);
		send_us(10001, TICKS - 1);

		// Random frames under several settings, the extremes among them.
		run_phase(16'd10000, 8'd50, 120, 20, 70, 1'b0);
		run_phase(16'hFFFF, 8'd255, 40, 30, 120, 1'b0);
		run_phase(16'd0, 8'd0, 30, 1, 3, 1'b0);
		run_phase(16'd3000, 8'd0, 130, 1, 3, 1'b1);
		repeat (4)
			run_phase(16'($urandom_range(2700, 20000)), 8'($urandom_range(0, 100)),
				35, 5, 60, 1'b0);
		idle_on = 1'b0;
		stall_on <= 1'b0;
		run_phase(16'd10000, 8'd20, 100, 10, 40, 1'b0);

		wait_drained();
		end_of_run <= 1'b1;
		repeat (2) @(posedge clk);
		if (error_count == 0)
			$display("ir_edge_interval_frame_decoder test passed");
		else
			$display("ir_edge_interval_frame_decoder test failed");
		$finish;
	end

endmodule
